/* src/bptc_pkg.sv */
package bptc_pkg;

    // Fixed field widths
    localparam int VAL_W      = 32;
    localparam int NARROW_W   = 16;
    localparam int CNT_W      = 32;
    localparam int LVL_W      = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TREE_DEPTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NARROW_MODE = 1'd1;

    // Status of one level cell as seen by the top level
    typedef struct packed {
        logic busy;  // a read or a pending result is in flight
        logic pend;  // an incremented count waits to be emitted
        logic fwd;   // the path value moves on to the next level
    } t_cell_stat;

endpackage

/* src/bptc_cell.sv */
module bptc_cell
    import bptc_pkg::*;
#(
    parameter int LEVEL     = 0,
    parameter int MAX_DEPTH = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_tok,
    input  logic [VAL_W-1:0]     i_val,
    input  logic                 i_grant,
    input  logic                 i_clr,
    input  logic [MAX_DEPTH-1:0] i_clr_addr,
    output t_cell_stat           o_stat,
    output logic [VAL_W-1:0]     o_fwd_val,
    output logic [CNT_W-1:0]     o_count,
    output logic [MAX_DEPTH:0]   o_node_index
);

    localparam int ADDR_W  = LEVEL + 1;
    localparam int ENTRIES = 2 ** ADDR_W;
    localparam int IDX_W   = MAX_DEPTH + 1;
    localparam int BASE    = ENTRIES - 2;

    logic [CNT_W-1:0]  r_mem [ENTRIES];
    logic [CNT_W-1:0]  r_rdata;
    logic [ADDR_W-1:0] r_addr;
    logic [VAL_W-1:0]  r_fwd_val;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_rd_v;
    logic              r_pend;

    logic [ADDR_W-1:0] w_addr;
    logic [CNT_W-1:0]  n_cnt;

    // Prefix of this level: the top LEVEL+1 bits of the aligned path value
    assign w_addr = i_val[VAL_W-1 -: ADDR_W];
    assign n_cnt  = r_rdata + 1'b1;

    // Counter memory: sweep clear, write back the increment, read on token
    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            r_mem[i_clr_addr[ADDR_W-1:0]] <= '0;
        end else if (r_rd_v) begin
            r_mem[r_addr] <= n_cnt;
        end
        if (i_tok) begin
            r_rdata <= r_mem[w_addr];
        end
    end

    // Payload: hold the address, the path value and the new count
    always_ff @(posedge i_clk) begin
        if (i_tok) begin
            r_addr    <= w_addr;
            r_fwd_val <= i_val;
        end
        if (r_rd_v) begin
            r_cnt <= n_cnt;
        end
    end

    // Control: read issued, then count pending until granted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_rd_v <= i_tok;
            if (r_rd_v) begin
                r_pend <= 1'b1;
            end else if (i_grant) begin
                r_pend <= 1'b0;
            end
        end
    end

    assign o_stat.busy  = r_rd_v | r_pend;
    assign o_stat.pend  = r_pend;
    assign o_stat.fwd   = r_rd_v;
    assign o_fwd_val    = r_fwd_val;
    assign o_count      = r_cnt;
    assign o_node_index = IDX_W'(BASE) + IDX_W'(r_addr);

endmodule

/* src/binary_prefix_tree_counter.sv */
// An item's first result reaches o_valid via the entry register, the read and pending
// registers of level 0 and the output register. Results follow one per cycle, one per
// level, for d levels (d = tree depth), unless i_ready stalls. A new item is taken only
// once the previous one has left every level. Reset (synchronous, active low) and every
// tree_depth write start a clearing pass of 2^MAX_DEPTH addresses that takes no input.
module binary_prefix_tree_counter
    import bptc_pkg::*;
#(
    parameter int MAX_DEPTH = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VAL_W-1:0]      i_value,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [MAX_DEPTH:0]    o_node_index,
    output logic [LVL_W-1:0]      o_level,
    output logic [CNT_W-1:0]      o_count,
    output logic                  o_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = MAX_DEPTH + 1;
    localparam int DW    = $clog2(MAX_DEPTH + 1);

    logic [DW-1:0]        r_depth;
    logic                 r_narrow;
    logic                 r_clr;
    logic [MAX_DEPTH-1:0] r_clr_addr;
    logic                 r_tok0;
    logic [VAL_W-1:0]     r_val0;
    logic                 r_out_valid;
    logic [IDX_W-1:0]     r_out_idx;
    logic [LVL_W-1:0]     r_out_lvl;
    logic [CNT_W-1:0]     r_out_cnt;
    logic                 r_out_last;

    logic [DW-1:0]        n_depth;
    t_cell_stat           w_stat     [MAX_DEPTH];
    logic [VAL_W-1:0]     w_fwd_val  [MAX_DEPTH];
    logic [CNT_W-1:0]     w_cnt      [MAX_DEPTH];
    logic [IDX_W-1:0]     w_idx      [MAX_DEPTH];
    logic [MAX_DEPTH-1:0] w_tok;
    logic [MAX_DEPTH-1:0] w_grant;
    logic [MAX_DEPTH-1:0] w_busy;
    logic                 w_any;
    logic                 w_slot;
    logic                 w_in_acc;
    logic                 w_depth_wr;
    logic [IDX_W-1:0]     w_sel_idx;
    logic [LVL_W-1:0]     w_sel_lvl;
    logic [CNT_W-1:0]     w_sel_cnt;
    logic                 w_sel_last;

    assign w_in_acc   = i_valid && o_ready;
    assign w_depth_wr = i_cfg_we && (i_cfg_idx == REG_TREE_DEPTH);
    assign w_slot     = !r_out_valid || i_ready;
    assign o_ready    = !r_clr && !r_tok0 && (w_busy == '0);

    // Saturate the written depth into 1..MAX_DEPTH
    always_comb begin
        if (i_cfg_data == '0) begin
            n_depth = DW'(1);
        end else if (int'(i_cfg_data) > MAX_DEPTH) begin
            n_depth = DW'(MAX_DEPTH);
        end else begin
            n_depth = DW'(i_cfg_data);
        end
    end

    // Configuration registers and the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth    <= DW'(MAX_DEPTH);
            r_narrow   <= 1'b0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we && (i_cfg_idx == REG_NARROW_MODE)) begin
                r_narrow <= i_cfg_data[0];
            end
            if (w_depth_wr) begin
                r_depth    <= n_depth;
                r_clr      <= 1'b1;
                r_clr_addr <= '0;
            end else if (r_clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clr <= 1'b0;
                end
            end
        end
    end

    // Entry: align the path so that its first bit sits at the top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok0 <= 1'b0;
        end else begin
            r_tok0 <= w_in_acc;
        end
        if (w_in_acc) begin
            r_val0 <= r_narrow ? {i_value[NARROW_W-1:0], {(VAL_W-NARROW_W){1'b0}}}
                               : i_value;
        end
    end

    // Row of level cells; the path value moves one level per cycle
    for (genvar l = 0; l < MAX_DEPTH; l++) begin : g_cell
        if (l == 0) begin : g_head
            assign w_tok[l] = r_tok0;
        end else begin : g_link
            assign w_tok[l] = w_stat[l-1].fwd && (DW'(l) < r_depth);
        end
        assign w_busy[l] = w_stat[l].busy;

        bptc_cell #(
            .LEVEL     (l),
            .MAX_DEPTH (MAX_DEPTH)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_tok        (w_tok[l]),
            .i_val        ((l == 0) ? r_val0 : w_fwd_val[(l == 0) ? 0 : l-1]),
            .i_grant      (w_grant[l]),
            .i_clr        (r_clr),
            .i_clr_addr   (r_clr_addr),
            .o_stat       (w_stat[l]),
            .o_fwd_val    (w_fwd_val[l]),
            .o_count      (w_cnt[l]),
            .o_node_index (w_idx[l])
        );
    end

    // Grant the lowest pending level: it belongs to the earliest result
    always_comb begin
        logic found;
        found      = 1'b0;
        w_grant    = '0;
        w_sel_idx  = w_idx[0];
        w_sel_lvl  = '0;
        w_sel_cnt  = w_cnt[0];
        w_sel_last = 1'b0;
        for (int l = 0; l < MAX_DEPTH; l++) begin
            if (!found && w_stat[l].pend) begin
                found      = 1'b1;
                w_grant[l] = w_slot;
                w_sel_idx  = w_idx[l];
                w_sel_lvl  = LVL_W'(l);
                w_sel_cnt  = w_cnt[l];
                w_sel_last = ((DW'(l) + 1'b1) == r_depth);
            end
        end
        w_any = found;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_slot) begin
            r_out_valid <= w_any;
        end
        if (w_slot && w_any) begin
            r_out_idx  <= w_sel_idx;
            r_out_lvl  <= w_sel_lvl;
            r_out_cnt  <= w_sel_cnt;
            r_out_last <= w_sel_last;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_node_index = r_out_idx;
    assign o_level      = r_out_lvl;
    assign o_count      = r_out_cnt;
    assign o_last       = r_out_last;

    // No item enters during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr |-> !o_ready)
        else $error("input taken during clearing sweep");

    // Only one path value travels down the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok))
        else $error("more than one level holds a token");

    // At most one level emits, and only into a free output slot
    a_one_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_grant != '0) |-> ($onehot(w_grant) && w_slot))
        else $error("bad grant to level cells");

    // A result held in the output stays until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_count) && $stable(o_node_index)))
        else $error("output result lost under stall");

endmodule

/* tb/bptc_checker.sv */
`timescale 1ns / 1ps

module bptc_checker
    import bptc_pkg::*;
#(
    parameter int MAX_DEPTH = 12
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [VAL_W-1:0]      i_value,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [MAX_DEPTH:0]    i_node_index,
    input  logic [LVL_W-1:0]      i_level,
    input  logic [CNT_W-1:0]      i_count,
    input  logic                  i_last,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int NODE_SLOTS = (1 << (MAX_DEPTH + 1)) - 2;
    localparam int PRINT_CAP  = 40;

    // One node update as the block reports it
    typedef struct packed {
        logic [MAX_DEPTH:0] node_index;
        logic [LVL_W-1:0]   level;
        logic [CNT_W-1:0]   count;
        logic               last;
    } t_node_update;

    logic [CNT_W-1:0] tally_mem [NODE_SLOTS];
    logic [LVL_W-1:0] depth_setting;
    logic             narrow_setting;
    t_node_update     node_updates_q[$];
    int               mismatches = 0;
    int               updates_waiting = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = updates_waiting;

    // Print one line per mismatch (capped) and count it
    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_CAP) begin
            $display("[chk] %0t ns: %s", $time, what);
        end
        mismatches++;
    endtask

    task automatic clear_tallies();
        foreach (tally_mem[k]) begin
            tally_mem[k] = '0;
        end
    endtask

    // Walk the path chosen by the leading bits, bump one counter per level
    // and queue the update that the block should report for it
    task automatic tally_path(input logic [VAL_W-1:0] value);
        int unsigned  levels;
        int unsigned  span;
        int unsigned  prefix;
        int unsigned  node;
        logic [VAL_W-1:0] path;
        t_node_update upd;
        if (depth_setting == 0) begin
            levels = 1;
        end else if (depth_setting > MAX_DEPTH) begin
            levels = MAX_DEPTH;
        end else begin
            levels = depth_setting;
        end
        span = narrow_setting ? NARROW_W : VAL_W;
        path = narrow_setting ? {{(VAL_W-NARROW_W){1'b0}}, value[NARROW_W-1:0]} : value;
        for (int lvl = 0; lvl < levels; lvl++) begin
            prefix = path >> (span - 1 - lvl);
            node   = (1 << (lvl + 1)) - 2 + prefix;
            if (node >= NODE_SLOTS) begin
                node = NODE_SLOTS - 1;
            end
            // counts wrap naturally at the counter width
            tally_mem[node]  = tally_mem[node] + 1'b1;
            upd.node_index   = node[MAX_DEPTH:0];
            upd.level        = lvl[LVL_W-1:0];
            upd.count        = tally_mem[node];
            upd.last         = (lvl == levels - 1);
            node_updates_q.push_back(upd);
        end
    endtask

    // Watch both channels and the register port at every edge
    always @(posedge i_clk) begin : watch
        t_node_update got;
        t_node_update want;
        if (!i_rst_n) begin
            depth_setting  = LVL_W'(MAX_DEPTH);
            narrow_setting = 1'b0;
            clear_tallies();
            node_updates_q.delete();
        end else begin
            // apply a register write at the same edge as the block
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TREE_DEPTH: begin
                        depth_setting = i_cfg_data;
                        clear_tallies();
                    end
                    REG_NARROW_MODE: begin
                        narrow_setting = i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && i_in_ready) begin
                tally_path(i_value);
            end
            // compare each result transaction with the oldest expectation
            if (i_out_valid && i_out_ready) begin
                got.node_index = i_node_index;
                got.level      = i_level;
                got.count      = i_count;
                got.last       = i_last;
                if (node_updates_q.size() == 0) begin
                    report_mismatch($sformatf(
                        "unexpected result: node %0d level %0d count %0d last %0b",
                        got.node_index, got.level, got.count, got.last));
                end else begin
                    want = node_updates_q.pop_front();
                    if (got !== want) begin
                        report_mismatch($sformatf(
                            "got/exp node %0d/%0d level %0d/%0d count %0d/%0d last %0b/%0b",
                            got.node_index, want.node_index, got.level, want.level,
                            got.count, want.count, got.last, want.last));
                    end
                end
            end
        end
        updates_waiting <= node_updates_q.size();
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import bptc_pkg::*;

    localparam int     MAX_DEPTH     = 12;
    localparam int     RESET_CYCLES  = 11;
    localparam int     SETTLE_CYCLES = 24;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     PHASE_ITEMS   = 30;
    localparam longint TIMEOUT_NS    = 2_000_000;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_valid    = 1'b0;
    logic                  o_ready;
    logic [VAL_W-1:0]      i_value    = '0;
    logic                  o_valid;
    logic                  i_ready    = 1'b0;
    logic [MAX_DEPTH:0]    o_node_index;
    logic [LVL_W-1:0]      o_level;
    logic [CNT_W-1:0]      o_count;
    logic                  o_last;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int               chk_fails;
    int               chk_pending;
    bit               idle_enable  = 1'b1;
    bit               hold_request = 1'b0;
    logic [VAL_W-1:0] value_pool [4];

    always #2 i_clk = ~i_clk;

    binary_prefix_tree_counter #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_node_index(o_node_index),
        .o_level     (o_level),
        .o_count     (o_count),
        .o_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    bptc_checker #(
        .MAX_DEPTH(MAX_DEPTH)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .i_in_ready  (o_ready),
        .i_value     (i_value),
        .i_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_node_index(o_node_index),
        .i_level     (o_level),
        .i_count     (o_count),
        .i_last      (o_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(chk_fails),
        .o_pending   (chk_pending)
    );

    // Offer one value, with an occasional gap first, and hold it until taken
    task automatic push_value(input logic [VAL_W-1:0] v);
        if (idle_enable && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Stop offering and wait until every node update has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    // Mix fresh values with revisits of a few paths, so that counts climb
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 3))
            0: return value_pool[$urandom_range(0, 3)];
            1: return value_pool[$urandom_range(0, 3)] ^ (32'h1 << $urandom_range(0, 31));
            default: return $urandom();
        endcase
    endfunction

    // Set the mode (and optionally the depth, which clears the tree), then stream values
    task automatic run_random_phase(input logic narrow, input logic [CFG_DATA_W-1:0] depth,
                                    input bit set_depth, input bit long_hold);
        drain_results();
        foreach (value_pool[k]) begin
            value_pool[k] = $urandom();
        end
        write_reg(REG_NARROW_MODE, CFG_DATA_W'(narrow));
        if (set_depth) begin
            write_reg(REG_TREE_DEPTH, depth);
        end
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (long_hold && n == 2) begin
                hold_request = 1'b1;
            end
            push_value(pick_value());
        end
    endtask

    // Result side: random back-pressure bursts, and one long hold on request
    initial begin : result_side
        int unsigned burst;
        @(posedge i_clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_enable && $urandom_range(0, 4) == 0) begin
                burst = $urandom_range(1, 5);
                i_ready <= 1'b0;
                repeat (burst) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("tb: failure");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full depth after reset: both extremes, the top bit alone, alternating bits
        push_value(32'h0000_0000);
        push_value(32'hFFFF_FFFF);
        push_value(32'h8000_0000);
        push_value(32'h7FFF_FFFF);
        push_value(32'h8000_0000);
        push_value(32'h5555_5555);
        push_value(32'hAAAA_AAAA);
        drain_results();

        // narrow mode: upper half ignored, counts carried over
        write_reg(REG_NARROW_MODE, CFG_DATA_W'(1));
        push_value(32'h0000_FFFF);
        push_value(32'hFFFF_0000);
        push_value(32'h0000_8000);
        push_value(32'hABCD_8000);
        push_value(32'h0000_7FFF);
        drain_results();

        // depth of zero acts as a single level
        write_reg(REG_TREE_DEPTH, CFG_DATA_W'(0));
        push_value(32'h0000_8000);
        push_value(32'h0000_0000);
        drain_results();

        // depth above the maximum saturates
        write_reg(REG_NARROW_MODE, CFG_DATA_W'(0));
        write_reg(REG_TREE_DEPTH, CFG_DATA_W'(15));
        push_value(32'hFFFF_FFFF);
        push_value(32'h0000_0001);
        drain_results();

        write_reg(REG_TREE_DEPTH, CFG_DATA_W'(1));
        push_value(32'h8000_0000);
        push_value(32'h7FFF_FFFF);

        // random phases; wrap of a count is out of reach in a run this short
        run_random_phase(1'b0, CFG_DATA_W'(MAX_DEPTH), 1'b1, 1'b1);
        run_random_phase(1'b1, CFG_DATA_W'(1), 1'b1, 1'b0);
        run_random_phase(1'b1, CFG_DATA_W'(MAX_DEPTH), 1'b1, 1'b0);
        run_random_phase(1'b0, CFG_DATA_W'(0), 1'b0, 1'b0);
        run_random_phase(1'($urandom_range(0, 1)), CFG_DATA_W'($urandom_range(0, 15)),
                         1'b1, 1'b0);
        run_random_phase(1'($urandom_range(0, 1)), CFG_DATA_W'($urandom_range(0, 15)),
                         1'b1, 1'b0);

        // closing phase at full rate on both sides
        drain_results();
        idle_enable = 1'b0;
        run_random_phase(1'($urandom_range(0, 1)), CFG_DATA_W'($urandom_range(0, 15)),
                         1'b1, 1'b0);
        drain_results();

        if (chk_fails == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
